>>> rtl/psp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psp_pkg: shared types and constants of the pat section parser
// request layout, parse phases, back-end states and pid bitmap geometry
// ----------------------------------------------------------------------------
package psp_pkg;

    // result kinds
    localparam logic KIND_ENTRY   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // bytes that the length value counts besides the entries: five header bytes and the crc
    localparam int SECT_FIXED = 9;
    localparam int CRC_BYTES  = 4;

    // pid bitmap: 8192 bits kept as rows of 32
    localparam int PID_W     = 13;
    localparam int MAP_ROW_W = 32;
    localparam int BIT_AW    = $clog2(MAP_ROW_W);
    localparam int MAP_ROWS  = (1 << PID_W) / MAP_ROW_W;
    localparam int ROW_AW    = $clog2(MAP_ROWS);

    // request queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // packed output payload width, rounded up to whole bytes
    localparam int OUT_DW = 120;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_SKIP,
        PH_TID,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_TSID_HI,
        PH_TSID_LO,
        PH_VER,
        PH_SEC,
        PH_LAST,
        PH_ENTRY,
        PH_CRC,
        PH_DONE
    } t_phase;

    typedef enum logic [1:0] {
        B_CLEAR,
        B_IDLE,
        B_CHECK
    } t_bstate;

    typedef struct packed {
        logic [7:0]  tid;
        logic [11:0] len;
        logic [15:0] tsid;
        logic [4:0]  ver;
        logic        cn;
        logic [7:0]  sec;
        logic [7:0]  last;
    } t_hdr;

    typedef struct packed {
        logic             kind;
        logic [15:0]      prog;
        logic [PID_W-1:0] pid;
        t_hdr             hdr;
        logic [31:0]      crc;
    } t_req;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage : psp_pkg
`default_nettype wire

>>> rtl/pat_section_parser_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pat_section_parser_unit: program association section parser
// parses pat section bytes, emits each newly seen program entry and a
// summary with the received crc at the end of every section
// ----------------------------------------------------------------------------
//
//  channel   dir  width  contents
//  --------  ---  -----  -----------------------------------------------------
//  s_axis    in   8 + 1  tdata: data_byte; tuser: section_start
//  m_axis    out  120+1  tdata: entry / summary fields; tuser: result_kind
//
//  one input byte per clock while tready is high; the parser decides each byte
//  in the cycle it is accepted and pushes at most one request per four bytes
//  the pid filter reads the bitmap row of each request, then writes it back,
//  before it takes the next; the four-deep request queue absorbs this
//  a result goes from its last byte through the queue, the held request with
//  its bitmap row read, and the output register
//  after reset the 256-row pid bitmap is cleared, one row a cycle; tready
//  stays low until the clear is done
//  an output stall fills the queue and then deasserts s_axis tready
//
// ----------------------------------------------------------------------------
module pat_section_parser_unit
    import psp_pkg::*;
(
    input  wire               i_clk,
    input  wire               i_rst_n,
    // slave side: section bytes
    input  wire               i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  wire [7:0]         i_s_axis_tdata,   // [7:0] data_byte
    input  wire               i_s_axis_tuser,   // [0] section_start
    // master side: results
    output logic              o_m_axis_tvalid,
    input  wire               i_m_axis_tready,
    // [15:0] program_number, [28:16] program_pid, [36:29] table_identifier,
    // [48:37] length_of_section, [64:49] stream_identifier, [69:65] version,
    // [70] current_next, [78:71] section_index, [86:79] final_section_index,
    // [118:87] received_crc, [119] zero
    output logic [OUT_DW-1:0] o_m_axis_tdata,
    output logic              o_m_axis_tuser    // [0] result_kind
);

    logic    in_accept;
    logic    push;
    t_req    push_req;
    t_req    head;
    t_q_stat q_stat;
    logic    pop;
    logic    back_ready;
    t_req    out_req;

    // a byte is taken only when the queue can hold whatever it produces
    assign o_s_axis_tready = back_ready && !q_stat.full;
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;

    // front: byte-level section parser
    psp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_byte   (i_s_axis_tdata),
        .i_start  (i_s_axis_tuser),
        .o_push   (push),
        .o_req    (push_req)
    );

    // decoupling queue
    psp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_req   (push_req),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (q_stat)
    );

    // back: pid bitmap filter and output register
    psp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_q_stat    (q_stat),
        .o_pop       (pop),
        .o_ready     (back_ready),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_out       (out_req)
    );

    // pack result fields, lowest field first
    assign o_m_axis_tdata = {1'b0,
                             out_req.crc,
                             out_req.hdr.last,
                             out_req.hdr.sec,
                             out_req.hdr.cn,
                             out_req.hdr.ver,
                             out_req.hdr.tsid,
                             out_req.hdr.len,
                             out_req.hdr.tid,
                             out_req.pid,
                             out_req.prog};
    assign o_m_axis_tuser = out_req.kind;

endmodule : pat_section_parser_unit
`default_nettype wire

>>> rtl/psp_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psp_ram: generic single-write, single-read memory
// one write port and one read port, read data registered
// ----------------------------------------------------------------------------
module psp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire                     i_clk,
    input  wire                     i_wr_en,
    input  wire [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire [WIDTH-1:0]         i_wr_data,
    input  wire [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]        o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule : psp_ram
`default_nettype wire

>>> rtl/psp_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psp_front: section byte parser
// walks the section header, assembles entries and crc, pushes requests
// ----------------------------------------------------------------------------
module psp_front
    import psp_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_accept,
    input  wire [7:0]  i_byte,
    input  wire        i_start,
    output logic       o_push,
    output t_req       o_req
);

    t_phase      r_phase, n_phase;
    logic [7:0]  r_skip, n_skip;
    logic [11:0] r_left, n_left;
    t_hdr        r_hdr, n_hdr;
    logic [31:0] r_asm, n_asm;

    logic [31:0] asm_nx;
    logic [11:0] left_nx;
    logic [7:0]  skip_nx;
    logic [11:0] area_sum;
    logic [11:0] area;

    assign asm_nx   = {r_asm[23:0], i_byte};
    assign left_nx  = r_left - 12'd1;
    assign skip_nx  = r_skip - 8'd1;
    // entry area rounded up to whole 4-byte entries
    assign area_sum = r_hdr.len - 12'(SECT_FIXED) + 12'd3;
    assign area     = (r_hdr.len > 12'(SECT_FIXED)) ? {area_sum[11:2], 2'b00} : 12'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_skip  <= '0;
            r_left  <= '0;
            r_hdr   <= '0;
            r_asm   <= '0;
        end else begin
            r_phase <= n_phase;
            r_skip  <= n_skip;
            r_left  <= n_left;
            r_hdr   <= n_hdr;
            r_asm   <= n_asm;
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_skip     = r_skip;
        n_left     = r_left;
        n_hdr      = r_hdr;
        n_asm      = r_asm;
        o_push     = 1'b0;
        o_req.kind = KIND_ENTRY;
        o_req.prog = asm_nx[31:16];
        o_req.pid  = asm_nx[PID_W-1:0];
        o_req.hdr  = r_hdr;
        o_req.crc  = '0;

        if (i_accept) begin
            if (i_start) begin
                // pointer field: restart, dropping any section in progress
                n_hdr   = '0;
                n_asm   = '0;
                n_left  = '0;
                n_skip  = i_byte;
                n_phase = (i_byte == 8'd0) ? PH_TID : PH_SKIP;
            end else begin
                case (r_phase)
                    PH_SKIP: begin
                        n_skip = skip_nx;
                        if (skip_nx == 8'd0) begin
                            n_phase = PH_TID;
                        end
                    end
                    PH_TID: begin
                        n_hdr.tid = i_byte;
                        n_phase   = PH_LEN_HI;
                    end
                    PH_LEN_HI: begin
                        n_asm   = {24'd0, i_byte};
                        n_phase = PH_LEN_LO;
                    end
                    PH_LEN_LO: begin
                        n_hdr.len = {r_asm[3:0], i_byte};
                        n_phase   = PH_TSID_HI;
                    end
                    PH_TSID_HI: begin
                        n_asm   = {24'd0, i_byte};
                        n_phase = PH_TSID_LO;
                    end
                    PH_TSID_LO: begin
                        n_hdr.tsid = {r_asm[7:0], i_byte};
                        n_phase    = PH_VER;
                    end
                    PH_VER: begin
                        n_hdr.ver = i_byte[5:1];
                        n_hdr.cn  = i_byte[0];
                        n_phase   = PH_SEC;
                    end
                    PH_SEC: begin
                        n_hdr.sec = i_byte;
                        n_phase   = PH_LAST;
                    end
                    PH_LAST: begin
                        n_hdr.last = i_byte;
                        n_left     = area;
                        n_asm      = '0;
                        if (area == 12'd0) begin
                            n_skip  = 8'(CRC_BYTES);
                            n_phase = PH_CRC;
                        end else begin
                            n_phase = PH_ENTRY;
                        end
                    end
                    PH_ENTRY: begin
                        n_asm  = asm_nx;
                        n_left = left_nx;
                        if (left_nx[1:0] == 2'd0) begin
                            // full entry; the back end filters seen pids
                            o_push = 1'b1;
                            n_asm  = '0;
                            if (left_nx == 12'd0) begin
                                n_skip  = 8'(CRC_BYTES);
                                n_phase = PH_CRC;
                            end
                        end
                    end
                    PH_CRC: begin
                        n_asm  = asm_nx;
                        n_skip = skip_nx;
                        if (skip_nx == 8'd0) begin
                            o_push     = 1'b1;
                            o_req.kind = KIND_SUMMARY;
                            o_req.prog = '0;
                            o_req.pid  = '0;
                            o_req.crc  = asm_nx;
                            n_phase    = PH_DONE;
                        end
                    end
                    default: begin
                        // idle or after crc: byte ignored
                    end
                endcase
            end
        end
    end

endmodule : psp_front
`default_nettype wire

>>> rtl/psp_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psp_queue: short request queue between parser and pid filter
// ----------------------------------------------------------------------------
module psp_queue
    import psp_pkg::*;
(
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  wire       i_push,
    input  wire t_req i_req,
    input  wire       i_pop,
    output t_req      o_head,
    output t_q_stat   o_stat
);

    t_req            r_slot [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr;
    logic [Q_AW-1:0] r_rd_ptr;
    logic [Q_AW:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + Q_AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (Q_AW+1)'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - (Q_AW+1)'(1);
            end
        end
    end

    assign o_head = r_slot[r_rd_ptr];
    assign o_stat = '{full:  (r_count == (Q_AW+1)'(Q_DEPTH)),
                      empty: (r_count == '0)};

endmodule : psp_queue
`default_nettype wire

>>> rtl/psp_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psp_back: pid filter and result register
// tests and sets the pid bitmap, drops seen entries, holds the result
// ----------------------------------------------------------------------------
module psp_back
    import psp_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire t_req    i_head,
    input  wire t_q_stat i_q_stat,
    output logic         o_pop,
    output logic         o_ready,
    input  wire          i_out_ready,
    output logic         o_out_valid,
    output t_req         o_out
);

    t_bstate               r_bst, n_bst;
    t_req                  r_req, n_req;
    logic [ROW_AW-1:0]     r_clr, n_clr;
    logic                  r_out_valid, n_out_valid;
    t_req                  r_out, n_out;

    logic                  wr_en;
    logic [ROW_AW-1:0]     wr_addr;
    logic [MAP_ROW_W-1:0]  wr_data;
    logic [ROW_AW-1:0]     rd_addr;
    logic [MAP_ROW_W-1:0]  rd_data;
    logic                  bit_seen;
    logic                  out_free;

    psp_ram #(
        .WIDTH (MAP_ROW_W),
        .DEPTH (MAP_ROWS)
    ) u_map (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bst       <= B_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_bst       <= n_bst;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req <= n_req;
        r_out <= n_out;
    end

    // held request keeps its row addressed so the read data stays current
    assign rd_addr  = (r_bst == B_CHECK) ? r_req.pid[PID_W-1:BIT_AW]
                                         : i_head.pid[PID_W-1:BIT_AW];
    assign bit_seen = rd_data[r_req.pid[BIT_AW-1:0]];
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_bst       = r_bst;
        n_req       = r_req;
        n_clr       = r_clr;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        o_pop       = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = r_req.pid[PID_W-1:BIT_AW];
        wr_data     = rd_data | (MAP_ROW_W'(1) << r_req.pid[BIT_AW-1:0]);

        case (r_bst)
            B_CLEAR: begin
                // one bitmap row cleared per cycle after reset
                wr_en   = 1'b1;
                wr_addr = r_clr;
                wr_data = '0;
                n_clr   = r_clr + ROW_AW'(1);
                if (r_clr == ROW_AW'(MAP_ROWS - 1)) begin
                    n_bst = B_IDLE;
                end
            end
            B_IDLE: begin
                if (!i_q_stat.empty) begin
                    o_pop = 1'b1;
                    n_req = i_head;
                    n_bst = B_CHECK;
                end
            end
            B_CHECK: begin
                if ((r_req.kind == KIND_ENTRY) && bit_seen) begin
                    n_bst = B_IDLE;
                end else if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = r_req;
                    wr_en       = (r_req.kind == KIND_ENTRY);
                    n_bst       = B_IDLE;
                end
            end
            default: begin
                n_bst = B_IDLE;
            end
        endcase
    end

    assign o_ready     = (r_bst != B_CLEAR);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule : psp_back
`default_nettype wire
